// ===== hdl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared widths, codes and reset values for the fan tacho calibration core.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int DIV_W            = 32;

  localparam int KIND_W    = 2;
  localparam int CNT_FW    = 16;
  localparam int RPM_W     = 20;
  localparam int CMPV_W    = 16;
  localparam int MODE_W    = 3;
  localparam int GAIN_W    = 32;
  localparam int NUM_W     = 32;
  localparam int PHASE_W   = 16;
  localparam int DUTY_W    = 22;

  localparam int IN_FIELDS_W  = CNT_FW + RPM_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RPM_W + CMPV_W + MODE_W + RPM_W + RPM_W + GAIN_W + RPM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_TACH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd3;

  localparam logic [MODE_W-1:0] MODE_UNCONF      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOW_START   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOW_SAMPLE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIGH_START  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HIGH_SAMPLE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CONTROL     = 3'd5;

  localparam logic [NUM_W-1:0]   RPM_NUM_RST  = 32'd1000000;
  localparam logic [CMPV_W-1:0]  AUTO_RLD_RST = 16'd65535;
  localparam logic [CMPV_W-1:0]  STOP_THR_RST = 16'd50000;
  localparam logic [PHASE_W-1:0] SETTLE_RST   = 16'd1000;

  localparam logic [RPM_W-1:0]   SPEED_MAX    = 20'hFFFFF;
  localparam logic [RPM_W-1:0]   TARGET_CAL   = 20'd1000;
  localparam logic [RPM_W-1:0]   LOW_CAL_INIT = 20'd999999;
  localparam logic [PHASE_W-1:0] PHASE_MAX    = 16'hFFFF;
  localparam logic [DUTY_W-1:0]  DUTY_PCT     = 22'd30;
  localparam logic [7:0]         DUTY_DEN     = 8'd100;

endpackage

`default_nettype wire

// ===== hdl/fct_serial_div.sv =====
// ----------------------------------------------------------------------------
// fct_serial_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_serial_div #(
  parameter int DVS_W = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [fct_pkg::DIV_W-1:0]  dividend,
  input  wire logic [DVS_W-1:0]           divisor,
  output logic                            done,
  output logic [fct_pkg::DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(fct_pkg::DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(fct_pkg::DIV_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [fct_pkg::DIV_W-1:0]  dvd_r;
  logic [DVS_W-1:0]           dvs_r;
  logic [DVS_W-1:0]           rem_r;

  logic [DVS_W:0]             rem_sh;
  logic                       fits;
  logic [DVS_W:0]             rem_sub;

  assign rem_sh  = {rem_r, dvd_r[fct_pkg::DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[fct_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

// ===== hdl/fan_tacho_calibration_controller_core.sv =====
// ----------------------------------------------------------------------------
// fan_tacho_calibration_controller_core
// Fan speed measurement and min/max calibration sequencer.
// ----------------------------------------------------------------------------
// Input words carry an event kind on in_tuser (tach edge, PWM tick, start
// calibration, set target) with the counter value and target in in_tdata.
// Every input word yields exactly one output word holding the state after
// that event. Registers are to be written through cfg_we/cfg_addr/cfg_wdata
// only while the core is idle; the core itself does not enforce this.
// Throughput is one word at a time: in_tready is high only while the core
// is idle. Events without a division go from acceptance to the output
// state, which loads out_tvalid and the output register as it returns to
// idle. A tach edge, a PWM tick in the low start phase and the tick that
// ends the high sample phase first run the shared bit-serial divider; the
// core waits in the divide state for its done flag and takes the result.
// A finished word sits in the output register while the next input word is
// accepted; if the receiver stalls, the core holds the following result and
// accepts nothing until the output register frees.
// Reset (rst_n low, synchronous) restores the register defaults, clears all
// calibration state to unconfigured and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tacho_calibration_controller_core #(
  parameter int COUNTER_BITS = fct_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // counter_value, target_rpm
  input  wire logic [fct_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind
  input  wire logic [fct_pkg::KIND_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // speed_rpm, compare_value, mode_now, min_rpm, max_rpm, gain_q16, target_now
  output logic [fct_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [fct_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CAP_W = (COUNTER_BITS < fct_pkg::CNT_FW) ? COUNTER_BITS : fct_pkg::CNT_FW;
  localparam int DVS_W = (COUNTER_BITS > fct_pkg::RPM_W) ? COUNTER_BITS : fct_pkg::RPM_W;
  localparam int CMP_W = (COUNTER_BITS > fct_pkg::CNT_FW) ? COUNTER_BITS : fct_pkg::CNT_FW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [1:0] OP_SPEED = 2'd0;
  localparam logic [1:0] OP_DUTY  = 2'd1;
  localparam logic [1:0] OP_GAIN  = 2'd2;

  // configuration
  logic [fct_pkg::NUM_W-1:0]   rpm_num_r;
  logic [fct_pkg::CMPV_W-1:0]  auto_rld_r;
  logic [fct_pkg::CMPV_W-1:0]  stop_thr_r;
  logic [fct_pkg::PHASE_W-1:0] settle_r;

  // control
  logic [1:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       out_valid_r;
  logic [fct_pkg::OUT_TDATA_W-1:0] out_data_r;

  // block state
  logic [fct_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [CAP_W-1:0]            prev_r, prev_nxt;
  logic [CAP_W-1:0]            last_r, last_nxt;
  logic [fct_pkg::RPM_W-1:0]   speed_r, speed_nxt;
  logic [fct_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [fct_pkg::RPM_W-1:0]   low_r, low_nxt;
  logic [fct_pkg::RPM_W-1:0]   high_r, high_nxt;
  logic [fct_pkg::GAIN_W-1:0]  gain_r, gain_nxt;
  logic [fct_pkg::RPM_W-1:0]   target_r, target_nxt;
  logic [fct_pkg::CMPV_W-1:0]  cmp_r, cmp_nxt;

  // input fields
  logic [fct_pkg::KIND_W-1:0]  in_kind;
  logic [fct_pkg::CNT_FW-1:0]  in_cnt;
  logic [fct_pkg::RPM_W-1:0]   in_tgt;
  logic [CAP_W-1:0]            in_cap;

  // helpers
  logic [COUNTER_BITS-1:0]     period;
  logic [COUNTER_BITS-1:0]     since;
  logic                        stopped;
  logic [fct_pkg::PHASE_W-1:0] phase_inc;
  logic                        start_done;
  logic                        sample_done;
  logic [fct_pkg::DUTY_W-1:0]  duty_prod;

  // divider
  logic                        div_start;
  logic [fct_pkg::DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]            div_dvs;
  logic                        div_done;
  logic [fct_pkg::DIV_W-1:0]   div_quo;
  logic [fct_pkg::CMPV_W-1:0]  duty_t;

  assign in_kind = in_tuser;
  assign in_cnt  = in_tdata[fct_pkg::CNT_FW-1:0];
  assign in_tgt  = in_tdata[fct_pkg::IN_FIELDS_W-1:fct_pkg::CNT_FW];
  assign in_cap  = in_cnt[CAP_W-1:0];

  assign in_tready = (state_r == ST_IDLE);

  assign period  = COUNTER_BITS'(in_cap) - COUNTER_BITS'(last_r);
  assign since   = COUNTER_BITS'(in_cap) - COUNTER_BITS'(last_r);
  assign stopped = CMP_W'(since) > CMP_W'(stop_thr_r);

  assign phase_inc   = (phase_r == fct_pkg::PHASE_MAX) ? phase_r : phase_r + 1'b1;
  assign start_done  = phase_r > settle_r;
  assign sample_done = phase_inc > settle_r;

  assign duty_prod = (fct_pkg::DUTY_W'(auto_rld_r) + 1'b1) * fct_pkg::DUTY_PCT;
  assign duty_t    = div_quo[fct_pkg::CMPV_W-1:0];

  fct_serial_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    mode_nxt   = mode_r;
    prev_nxt   = prev_r;
    last_nxt   = last_r;
    speed_nxt  = speed_r;
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    gain_nxt   = gain_r;
    target_nxt = target_r;
    cmp_nxt    = cmp_r;
    div_start  = 1'b0;
    div_dvd    = fct_pkg::DIV_W'(rpm_num_r);
    div_dvs    = DVS_W'(period);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_OUT;
          case (in_kind)
            fct_pkg::KIND_TACH: begin
              prev_nxt  = last_r;
              last_nxt  = in_cap;
              op_nxt    = OP_SPEED;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
            fct_pkg::KIND_TICK: begin
              case (mode_r)
                fct_pkg::MODE_LOW_START: begin
                  if (start_done) begin
                    phase_nxt = '0;
                    mode_nxt  = fct_pkg::MODE_LOW_SAMPLE;
                  end else begin
                    phase_nxt = phase_inc;
                  end
                  div_dvd   = fct_pkg::DIV_W'(duty_prod);
                  div_dvs   = DVS_W'(fct_pkg::DUTY_DEN);
                  op_nxt    = OP_DUTY;
                  div_start = 1'b1;
                  state_nxt = ST_DIV;
                end
                fct_pkg::MODE_LOW_SAMPLE: begin
                  if (sample_done) begin
                    phase_nxt = '0;
                    low_nxt   = speed_r;
                    mode_nxt  = fct_pkg::MODE_HIGH_START;
                  end else begin
                    phase_nxt = phase_inc;
                  end
                end
                fct_pkg::MODE_HIGH_START: begin
                  cmp_nxt = auto_rld_r;
                  if (start_done) begin
                    phase_nxt = '0;
                    mode_nxt  = fct_pkg::MODE_HIGH_SAMPLE;
                  end else begin
                    phase_nxt = phase_inc;
                  end
                end
                fct_pkg::MODE_HIGH_SAMPLE: begin
                  if (sample_done) begin
                    phase_nxt  = '0;
                    high_nxt   = speed_r;
                    target_nxt = fct_pkg::TARGET_CAL;
                    mode_nxt   = fct_pkg::MODE_CONTROL;
                    div_dvd    = {auto_rld_r, {fct_pkg::CMPV_W{1'b0}}};
                    div_dvs    = DVS_W'(speed_r);
                    op_nxt     = OP_GAIN;
                    div_start  = 1'b1;
                    state_nxt  = ST_DIV;
                  end else begin
                    phase_nxt = phase_inc;
                  end
                end
                default: begin
                end
              endcase
              if (mode_nxt == fct_pkg::MODE_UNCONF || stopped) begin
                speed_nxt = '0;
              end
            end
            fct_pkg::KIND_CAL: begin
              phase_nxt = '0;
              low_nxt   = fct_pkg::LOW_CAL_INIT;
              high_nxt  = '0;
              mode_nxt  = fct_pkg::MODE_LOW_START;
            end
            default: begin
              if (in_tgt > high_r) begin
                target_nxt = high_r;
              end else if (in_tgt < low_r) begin
                target_nxt = low_r;
              end else begin
                target_nxt = in_tgt;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
          case (op_r)
            OP_SPEED: begin
              speed_nxt = (|div_quo[fct_pkg::DIV_W-1:fct_pkg::RPM_W]) ? fct_pkg::SPEED_MAX :
                          div_quo[fct_pkg::RPM_W-1:0];
            end
            OP_DUTY: begin
              cmp_nxt = (duty_t == '0) ? '0 : duty_t - 1'b1;
            end
            default: begin
              gain_nxt = div_quo;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_num_r  <= fct_pkg::RPM_NUM_RST;
      auto_rld_r <= fct_pkg::AUTO_RLD_RST;
      stop_thr_r <= fct_pkg::STOP_THR_RST;
      settle_r   <= fct_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        fct_pkg::CFG_RPM_NUM:  rpm_num_r  <= cfg_wdata;
        fct_pkg::CFG_AUTO_RLD: auto_rld_r <= cfg_wdata[fct_pkg::CMPV_W-1:0];
        fct_pkg::CFG_STOP_THR: stop_thr_r <= cfg_wdata[fct_pkg::CMPV_W-1:0];
        fct_pkg::CFG_SETTLE:   settle_r   <= cfg_wdata[fct_pkg::PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= OP_SPEED;
      mode_r   <= fct_pkg::MODE_UNCONF;
      prev_r   <= '0;
      last_r   <= '0;
      speed_r  <= '0;
      phase_r  <= '0;
      low_r    <= '0;
      high_r   <= '0;
      gain_r   <= '0;
      target_r <= '0;
      cmp_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      mode_r   <= mode_nxt;
      prev_r   <= prev_nxt;
      last_r   <= last_nxt;
      speed_r  <= speed_nxt;
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      gain_r   <= gain_nxt;
      target_r <= target_nxt;
      cmp_r    <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {{(fct_pkg::OUT_TDATA_W - fct_pkg::OUT_FIELDS_W){1'b0}},
                     target_r, gain_r, high_r, low_r, mode_r, cmp_r, speed_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fan tacho calibration core.
// ----------------------------------------------------------------------------
// Event words (tach edge, PWM tick, start calibration, set target) are driven
// into the stream input. A behavioural copy of the speed measurement and the
// calibration sequencer predicts each output word on acceptance. The checker
// compares every returned word field by field with the oldest prediction.
// Directed runs cover the speed limits, the low duty clamp, the saturating
// gain and the held phase. Random phases then vary the registers and drive
// mostly well-formed calibration runs. Both sides idle in bursts, the receiver
// holds off for a long stretch once, and the final stretch runs gap-free.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [fct_pkg::RPM_W-1:0]  speed;
    logic [fct_pkg::CMPV_W-1:0] cmp;
    logic [fct_pkg::MODE_W-1:0] mode;
    logic [fct_pkg::RPM_W-1:0]  min_rpm;
    logic [fct_pkg::RPM_W-1:0]  max_rpm;
    logic [fct_pkg::GAIN_W-1:0] gain;
    logic [fct_pkg::RPM_W-1:0]  target;
  } fan_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fct_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [fct_pkg::KIND_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fct_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we;
  logic [fct_pkg::CFG_IDX_W-1:0]   cfg_addr;
  logic [fct_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  fan_tacho_calibration_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // register copies
  logic [fct_pkg::NUM_W-1:0]   numerator_r;
  logic [fct_pkg::CMPV_W-1:0]  reload_r;
  logic [fct_pkg::CMPV_W-1:0]  stop_thr_r;
  logic [fct_pkg::PHASE_W-1:0] settle_r;

  // sequencer copy
  logic [fct_pkg::MODE_W-1:0]  cal_mode;
  logic [fct_pkg::CNT_FW-1:0]  cap_prev;
  logic [fct_pkg::CNT_FW-1:0]  cap_last;
  logic [fct_pkg::RPM_W-1:0]   speed_now;
  logic [fct_pkg::PHASE_W-1:0] phase_cnt;
  logic [fct_pkg::RPM_W-1:0]   low_rpm;
  logic [fct_pkg::RPM_W-1:0]   high_rpm;
  logic [fct_pkg::GAIN_W-1:0]  gain_now;
  logic [fct_pkg::RPM_W-1:0]   target_set;
  logic [fct_pkg::CMPV_W-1:0]  cmp_now;

  fan_word_t                   expected_words[$];
  int                          n_errors;
  bit                          traffic_gaps;
  bit                          hold_req;
  logic [fct_pkg::CNT_FW-1:0]  fan_pos;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void bump_phase();
    if (phase_cnt != fct_pkg::PHASE_MAX) phase_cnt++;
  endfunction

  // start phases test the old count
  function automatic bit start_phase_over();
    bit done;
    done = phase_cnt > settle_r;
    bump_phase();
    if (done) phase_cnt = '0;
    return done;
  endfunction

  // sample phases count first
  function automatic bit sample_phase_over();
    bump_phase();
    if (phase_cnt > settle_r) begin
      phase_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_word(input logic [fct_pkg::KIND_W-1:0] kind,
                              input logic [fct_pkg::CNT_FW-1:0] cnt,
                              input logic [fct_pkg::RPM_W-1:0] tgt);
    fan_word_t                  w;
    logic [fct_pkg::CNT_FW-1:0] diff;
    logic [31:0]                quo;
    logic [31:0]                duty;
    logic [63:0]                wide;
    case (kind)
      fct_pkg::KIND_TACH: begin
        cap_prev = cap_last;
        cap_last = cnt;
        diff = cap_last - cap_prev;
        if (diff == 0) begin
          speed_now = fct_pkg::SPEED_MAX;
        end else begin
          quo = numerator_r / 32'(diff);
          speed_now = (quo > 32'(fct_pkg::SPEED_MAX)) ? fct_pkg::SPEED_MAX :
                      quo[fct_pkg::RPM_W-1:0];
        end
      end
      fct_pkg::KIND_TICK: begin
        case (cal_mode)
          fct_pkg::MODE_LOW_START: begin
            duty = (32'(fct_pkg::DUTY_PCT) * (32'(reload_r) + 32'd1)) /
                   32'(fct_pkg::DUTY_DEN);
            cmp_now = (duty == 0) ? '0 : 16'(duty - 32'd1);
            if (start_phase_over()) cal_mode = fct_pkg::MODE_LOW_SAMPLE;
          end
          fct_pkg::MODE_LOW_SAMPLE: begin
            if (sample_phase_over()) begin
              low_rpm = speed_now;
              cal_mode = fct_pkg::MODE_HIGH_START;
            end
          end
          fct_pkg::MODE_HIGH_START: begin
            cmp_now = reload_r;
            if (start_phase_over()) cal_mode = fct_pkg::MODE_HIGH_SAMPLE;
          end
          fct_pkg::MODE_HIGH_SAMPLE: begin
            if (sample_phase_over()) begin
              high_rpm = speed_now;
              wide = {32'h0, reload_r, 16'h0};
              gain_now = (high_rpm == 0) ? 32'hFFFF_FFFF : 32'(wide / 64'(high_rpm));
              target_set = fct_pkg::TARGET_CAL;
              cal_mode = fct_pkg::MODE_CONTROL;
            end
          end
          default: ;
        endcase
        if (cal_mode == fct_pkg::MODE_UNCONF) begin
          speed_now = '0;
        end else begin
          diff = cnt - cap_last;
          if (diff > stop_thr_r) speed_now = '0;
        end
      end
      fct_pkg::KIND_CAL: begin
        phase_cnt = '0;
        low_rpm = fct_pkg::LOW_CAL_INIT;
        high_rpm = '0;
        cal_mode = fct_pkg::MODE_LOW_START;
      end
      default: begin
        if (tgt > high_rpm) target_set = high_rpm;
        else if (tgt < low_rpm) target_set = low_rpm;
        else target_set = tgt;
      end
    endcase
    w.speed = speed_now;
    w.cmp = cmp_now;
    w.mode = cal_mode;
    w.min_rpm = low_rpm;
    w.max_rpm = high_rpm;
    w.gain = gain_now;
    w.target = target_set;
    expected_words.push_back(w);
  endtask

  task automatic send_word(input logic [fct_pkg::KIND_W-1:0] kind,
                           input logic [fct_pkg::CNT_FW-1:0] cnt,
                           input logic [fct_pkg::RPM_W-1:0] tgt);
    if (traffic_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {{(fct_pkg::IN_TDATA_W - fct_pkg::CNT_FW - fct_pkg::RPM_W){1'b0}}, tgt, cnt};
    do @(posedge clk); while (!in_tready);
    predict_word(kind, cnt, tgt);
  endtask

  // sender pause until every word is back, plus the divider latency
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fct_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fct_pkg::CFG_RPM_NUM:  numerator_r = val;
      fct_pkg::CFG_AUTO_RLD: reload_r = val[fct_pkg::CMPV_W-1:0];
      fct_pkg::CFG_STOP_THR: stop_thr_r = val[fct_pkg::CMPV_W-1:0];
      default:               settle_r = val[fct_pkg::PHASE_W-1:0];
    endcase
  endtask

  task automatic send_random_word(input bit shaped);
    int unsigned                pick;
    logic [fct_pkg::CNT_FW-1:0] period;
    logic [fct_pkg::RPM_W-1:0]  tgt;
    tgt = fct_pkg::RPM_W'($urandom);
    pick = shaped ? $urandom_range(0, 49) : 47;
    if (pick <= 18) begin
      case ($urandom_range(0, 15))
        0:       period = '0;
        1:       period = fct_pkg::CNT_FW'($urandom);
        default: period = fct_pkg::CNT_FW'($urandom_range(1, 3000));
      endcase
      fan_pos = fan_pos + period;
      send_word(fct_pkg::KIND_TACH, fan_pos, tgt);
    end else if (pick <= 38) begin
      if ($urandom_range(0, 7) == 0)
        send_word(fct_pkg::KIND_TICK, fct_pkg::CNT_FW'($urandom), tgt);
      else
        send_word(fct_pkg::KIND_TICK, fan_pos + fct_pkg::CNT_FW'($urandom_range(0, 800)), tgt);
    end else if (pick <= 44) begin
      if ($urandom_range(0, 1) == 0) tgt = fct_pkg::RPM_W'($urandom_range(0, 20000));
      send_word(fct_pkg::KIND_TARGET, fct_pkg::CNT_FW'($urandom), tgt);
    end else if (pick <= 48) begin
      send_word(fct_pkg::KIND_W'($urandom_range(0, 3)), fct_pkg::CNT_FW'($urandom), tgt);
    end else begin
      send_word(fct_pkg::KIND_CAL, fct_pkg::CNT_FW'($urandom), tgt);
    end
  endtask

  task automatic randomise_regs();
    case ($urandom_range(0, 4))
      0: write_reg(fct_pkg::CFG_RPM_NUM, 32'd1);
      1: write_reg(fct_pkg::CFG_RPM_NUM, 32'hFFFF_FFFF);
      2: write_reg(fct_pkg::CFG_RPM_NUM, 32'(fct_pkg::RPM_NUM_RST));
      3: write_reg(fct_pkg::CFG_RPM_NUM, $urandom);
      default: write_reg(fct_pkg::CFG_RPM_NUM, $urandom_range(1000, 50000000));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(fct_pkg::CFG_AUTO_RLD, 32'd0);
      1: write_reg(fct_pkg::CFG_AUTO_RLD, 32'd1);
      2: write_reg(fct_pkg::CFG_AUTO_RLD, 32'd3);
      3: write_reg(fct_pkg::CFG_AUTO_RLD, 32'd4);
      4: write_reg(fct_pkg::CFG_AUTO_RLD, 32'd65535);
      default: write_reg(fct_pkg::CFG_AUTO_RLD, $urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(fct_pkg::CFG_STOP_THR, 32'd0);
      1: write_reg(fct_pkg::CFG_STOP_THR, 32'd65535);
      2: write_reg(fct_pkg::CFG_STOP_THR, $urandom_range(0, 65535));
      default: write_reg(fct_pkg::CFG_STOP_THR, $urandom_range(500, 4000));
    endcase
    case ($urandom_range(0, 15))
      13: write_reg(fct_pkg::CFG_SETTLE, 32'd0);
      14: write_reg(fct_pkg::CFG_SETTLE, 32'd65535);
      15: write_reg(fct_pkg::CFG_SETTLE, $urandom_range(0, 65535));
      10, 11, 12: write_reg(fct_pkg::CFG_SETTLE, $urandom_range(4, 12));
      default: write_reg(fct_pkg::CFG_SETTLE, $urandom_range(0, 3));
    endcase
  endtask

  task automatic test_unconfigured();
    send_word(fct_pkg::KIND_TICK, 16'h0000, 20'h00000);
    send_word(fct_pkg::KIND_TACH, 16'h0000, 20'h00000);
    send_word(fct_pkg::KIND_TACH, 16'hFFFF, 20'hFFFFF);
    send_word(fct_pkg::KIND_TACH, 16'h0000, 20'h00000);
    send_word(fct_pkg::KIND_TARGET, 16'hFFFF, 20'hFFFFF);
  endtask

  task automatic test_speed_limits();
    wait_drain();
    write_reg(fct_pkg::CFG_RPM_NUM, 32'hFFFF_FFFF);
    send_word(fct_pkg::KIND_TACH, 16'h1234, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h1235, 20'h0);
    wait_drain();
    write_reg(fct_pkg::CFG_RPM_NUM, 32'd1);
    send_word(fct_pkg::KIND_TACH, 16'h1236, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h1238, 20'h0);
  endtask

  // fast run, low duty clamped at zero
  task automatic test_calibration();
    wait_drain();
    write_reg(fct_pkg::CFG_RPM_NUM, 32'(fct_pkg::RPM_NUM_RST));
    write_reg(fct_pkg::CFG_AUTO_RLD, 32'd0);
    write_reg(fct_pkg::CFG_STOP_THR, 32'd65535);
    write_reg(fct_pkg::CFG_SETTLE, 32'd0);
    send_word(fct_pkg::KIND_CAL, 16'h0, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h0100, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h0200, 20'h0);
    repeat (6) send_word(fct_pkg::KIND_TICK, 16'h0210, 20'h0);
    send_word(fct_pkg::KIND_TARGET, 16'h0, 20'hFFFFF);
  endtask

  task automatic test_settle_hold();
    wait_drain();
    write_reg(fct_pkg::CFG_AUTO_RLD, 32'd65535);
    write_reg(fct_pkg::CFG_STOP_THR, 32'd0);
    write_reg(fct_pkg::CFG_SETTLE, 32'd65535);
    send_word(fct_pkg::KIND_CAL, 16'h0, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h0300, 20'h0);
    send_word(fct_pkg::KIND_TICK, 16'h0301, 20'h0);
    send_word(fct_pkg::KIND_TICK, 16'h0300, 20'h0);
  endtask

  // stopped fan throughout, so the max speed is zero
  task automatic test_zero_max_gain();
    wait_drain();
    write_reg(fct_pkg::CFG_SETTLE, 32'd0);
    send_word(fct_pkg::KIND_CAL, 16'h0, 20'h0);
    send_word(fct_pkg::KIND_TACH, 16'h0400, 20'h0);
    repeat (6) send_word(fct_pkg::KIND_TICK, 16'h0500, 20'h0);
    send_word(fct_pkg::KIND_TARGET, 16'h0, 20'd77);
  endtask

  task automatic test_random_phases();
    bit shaped;
    repeat (12) begin
      wait_drain();
      randomise_regs();
      traffic_gaps = ($urandom_range(0, 3) != 0);
      shaped = ($urandom_range(0, 4) != 0);
      if (shaped) begin
        send_word(fct_pkg::KIND_CAL, fct_pkg::CNT_FW'($urandom), fct_pkg::RPM_W'($urandom));
      end
      repeat (30) send_random_word(shaped);
    end
    traffic_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drain();
    hold_req = 1'b1;
    repeat (25) send_random_word(1'b1);
    wait_drain();
  endtask

  task automatic test_no_gaps();
    traffic_gaps = 1'b0;
    wait_drain();
    write_reg(fct_pkg::CFG_SETTLE, 32'd1);
    send_word(fct_pkg::KIND_CAL, 16'h0, 20'h0);
    repeat (40) send_random_word(1'b1);
  endtask

  // receiver side
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    fan_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual %h", $time, out_tdata);
        n_errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("speed_rpm", 32'(want.speed), 32'(out_tdata[19:0]));
        check_field("compare_value", 32'(want.cmp), 32'(out_tdata[35:20]));
        check_field("mode_now", 32'(want.mode), 32'(out_tdata[38:36]));
        check_field("min_rpm", 32'(want.min_rpm), 32'(out_tdata[58:39]));
        check_field("max_rpm", 32'(want.max_rpm), 32'(out_tdata[78:59]));
        check_field("gain_q16", want.gain, out_tdata[110:79]);
        check_field("target_now", 32'(want.target), 32'(out_tdata[130:111]));
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL fan_tacho_calibration_controller_core");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = fct_pkg::KIND_TACH;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = fct_pkg::CFG_RPM_NUM;
    cfg_wdata = '0;
    n_errors = 0;
    traffic_gaps = 1'b1;
    hold_req = 1'b0;
    fan_pos = '0;
    numerator_r = fct_pkg::RPM_NUM_RST;
    reload_r = fct_pkg::AUTO_RLD_RST;
    stop_thr_r = fct_pkg::STOP_THR_RST;
    settle_r = fct_pkg::SETTLE_RST;
    cal_mode = fct_pkg::MODE_UNCONF;
    cap_prev = '0;
    cap_last = '0;
    speed_now = '0;
    phase_cnt = '0;
    low_rpm = '0;
    high_rpm = '0;
    gain_now = '0;
    target_set = '0;
    cmp_now = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_unconfigured();
    test_speed_limits();
    test_calibration();
    test_settle_hold();
    test_zero_max_gain();
    test_random_phases();
    test_backpressure();
    test_no_gaps();
    wait_drain();

    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("PASS fan_tacho_calibration_controller_core");
    end else begin
      $display("FAIL fan_tacho_calibration_controller_core");
    end
    $finish;
  end

endmodule
